@@ rtl/dmx_pkg.sv @@
// ----------------------------------------------------------------------------
// DMX transmitter package
// Shared widths, register indexes and the phase encoding of the transmitter.
// ----------------------------------------------------------------------------
package dmx_pkg;

   localparam int MAX_SLOTS       = 16;
   localparam int SLOT_IDX_WIDTH  = 4;
   localparam int SLOT_CNT_WIDTH  = 5;
   localparam int BYTE_WIDTH      = 8;
   localparam int TICK_WIDTH      = 16;
   localparam int BIT_POS_WIDTH   = 4;
   localparam int CSR_IDX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int REQ_DATA_WIDTH  = 16;
   localparam int RSP_DATA_WIDTH  = 8;
   localparam int STOP_BITS       = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAB_TICKS   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_START_TICKS = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DATA_TICKS  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STOP_TICKS  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BREAK_TICKS = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLOT_COUNT  = 3'd5;

   localparam logic [TICK_WIDTH-1:0]     MAB_TICKS_RST   = 16'd12;
   localparam logic [TICK_WIDTH-1:0]     START_TICKS_RST = 16'd4;
   localparam logic [TICK_WIDTH-1:0]     DATA_TICKS_RST  = 16'd4;
   localparam logic [TICK_WIDTH-1:0]     STOP_TICKS_RST  = 16'd4;
   localparam logic [TICK_WIDTH-1:0]     BREAK_TICKS_RST = 16'd100;
   localparam logic [SLOT_CNT_WIDTH-1:0] SLOT_COUNT_RST  = 5'd12;

   localparam bit FUNC_WRITE = 1'b0;
   localparam bit FUNC_TICK  = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_MAB   = 6'b000010,
      PH_START = 6'b000100,
      PH_DATA  = 6'b001000,
      PH_STOP  = 6'b010000,
      PH_BREAK = 6'b100000
   } phase_type;

endpackage

@@ rtl/dmx_packet_transmitter.sv @@
// ----------------------------------------------------------------------------
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; a stalled result
// holds off new requests until it is taken.
// Reset is synchronous and active high; it loads the timing registers with
// their defaults and clears the phase state and the slot store at once.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// DMX packet transmitter
// Drives a DMX-style serial line: mark-after-break, framed slot bytes and a
// closing break, each request being either a slot write or one tick.
// ----------------------------------------------------------------------------
module dmx_packet_transmitter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot_index [3:0], slot_value [11:4], start_req [12], zero [15:13]
   input  logic [dmx_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // func [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // line_level [0], busy_res [1], zero [7:2]
   output logic [dmx_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [dmx_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [dmx_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int BW = dmx_pkg::BIT_POS_WIDTH;
   localparam int SW = dmx_pkg::SLOT_CNT_WIDTH;
   localparam logic [BW-1:0] LAST_DATA_BIT = BW'(dmx_pkg::BYTE_WIDTH - 1);
   localparam logic [BW-1:0] LAST_STOP_BIT = BW'(dmx_pkg::STOP_BITS - 1);
   localparam logic [SW-1:0] MAX_SLOTS_C   = SW'(dmx_pkg::MAX_SLOTS);

   logic [dmx_pkg::TICK_WIDTH-1:0]     mab_ticks_ff, start_ticks_ff, data_ticks_ff;
   logic [dmx_pkg::TICK_WIDTH-1:0]     stop_ticks_ff, break_ticks_ff;
   logic [SW-1:0]                      slot_count_ff;

   dmx_pkg::phase_type                 phase_ff, phase_in;
   logic [dmx_pkg::TICK_WIDTH-1:0]     tick_count_ff, tick_count_in;
   logic [BW-1:0]                      bit_pos_ff, bit_pos_in;
   logic [dmx_pkg::SLOT_IDX_WIDTH-1:0] slot_pos_ff, slot_pos_in;
   logic [dmx_pkg::BYTE_WIDTH-1:0]     shift_byte_ff, shift_byte_in;
   logic                               line_ff, line_in;
   logic [dmx_pkg::BYTE_WIDTH-1:0]     slot_store_ff [dmx_pkg::MAX_SLOTS];

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_line_ff, rsp_busy_ff, rsp_done_ff;

   logic                               req_accept;
   logic                               req_func;
   logic [dmx_pkg::SLOT_IDX_WIDTH-1:0] req_slot_index;
   logic [dmx_pkg::BYTE_WIDTH-1:0]     req_slot_value;
   logic                               req_start;

   logic                               store_we;
   logic                               done;
   logic [dmx_pkg::TICK_WIDTH-1:0]     phase_len;
   logic [dmx_pkg::TICK_WIDTH-1:0]     tick_inc;
   logic [SW-1:0]                      eff_slots;
   logic [SW-1:0]                      slot_sum;
   logic [dmx_pkg::SLOT_IDX_WIDTH-1:0] rd_addr;
   logic [dmx_pkg::BYTE_WIDTH-1:0]     rd_byte;

   assign req_tready     = !rsp_valid_ff || rsp_tready;
   assign req_accept     = req_tvalid && req_tready;
   assign req_func       = req_tuser;
   assign req_slot_index = req_tdata[3:0];
   assign req_slot_value = req_tdata[11:4];
   assign req_start      = req_tdata[12];

   assign eff_slots = (slot_count_ff > MAX_SLOTS_C) ? MAX_SLOTS_C : slot_count_ff;
   assign slot_sum  = SW'(slot_pos_ff) + SW'(1);
   assign tick_inc  = tick_count_ff + dmx_pkg::TICK_WIDTH'(1);
   assign rd_addr   = (phase_ff == dmx_pkg::PH_MAB) ? '0 : slot_sum[dmx_pkg::SLOT_IDX_WIDTH-1:0];
   assign rd_byte   = slot_store_ff[rd_addr];

   always_comb begin
      unique case (phase_ff)
         dmx_pkg::PH_MAB:   phase_len = mab_ticks_ff;
         dmx_pkg::PH_START: phase_len = start_ticks_ff;
         dmx_pkg::PH_DATA:  phase_len = data_ticks_ff;
         dmx_pkg::PH_STOP:  phase_len = stop_ticks_ff;
         dmx_pkg::PH_BREAK: phase_len = break_ticks_ff;
         default:           phase_len = '0;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      bit_pos_in    = bit_pos_ff;
      slot_pos_in   = slot_pos_ff;
      shift_byte_in = shift_byte_ff;
      line_in       = line_ff;
      store_we      = 1'b0;
      done          = 1'b0;
      if (req_accept) begin
         if (req_func == dmx_pkg::FUNC_WRITE) begin
            store_we = (phase_ff == dmx_pkg::PH_IDLE);
         end else if (phase_ff == dmx_pkg::PH_IDLE) begin
            if (req_start) begin
               phase_in      = dmx_pkg::PH_MAB;
               tick_count_in = '0;
               line_in       = 1'b1;
            end
         end else if (tick_inc < phase_len) begin
            tick_count_in = tick_inc;
         end else begin
            tick_count_in = '0;
            unique case (phase_ff)
               dmx_pkg::PH_MAB: begin
                  slot_pos_in = '0;
                  line_in     = 1'b0;
                  if (eff_slots == '0) begin
                     phase_in = dmx_pkg::PH_BREAK;
                  end else begin
                     phase_in      = dmx_pkg::PH_START;
                     bit_pos_in    = '0;
                     shift_byte_in = rd_byte;
                  end
               end
               dmx_pkg::PH_START: begin
                  phase_in   = dmx_pkg::PH_DATA;
                  bit_pos_in = '0;
                  line_in    = shift_byte_ff[0];
               end
               dmx_pkg::PH_DATA: begin
                  shift_byte_in = shift_byte_ff >> 1;
                  if (bit_pos_ff == LAST_DATA_BIT) begin
                     phase_in   = dmx_pkg::PH_STOP;
                     bit_pos_in = '0;
                     line_in    = 1'b1;
                  end else begin
                     bit_pos_in = bit_pos_ff + BW'(1);
                     line_in    = shift_byte_ff[1];
                  end
               end
               dmx_pkg::PH_STOP: begin
                  if (bit_pos_ff != LAST_STOP_BIT) begin
                     bit_pos_in = bit_pos_ff + BW'(1);
                  end else if (slot_sum >= eff_slots) begin
                     phase_in   = dmx_pkg::PH_BREAK;
                     bit_pos_in = LAST_STOP_BIT + BW'(1);
                     line_in    = 1'b0;
                  end else begin
                     phase_in      = dmx_pkg::PH_START;
                     slot_pos_in   = rd_addr;
                     bit_pos_in    = '0;
                     shift_byte_in = rd_byte;
                     line_in       = 1'b0;
                  end
               end
               default: begin
                  phase_in    = dmx_pkg::PH_IDLE;
                  line_in     = 1'b0;
                  bit_pos_in  = '0;
                  slot_pos_in = '0;
                  done        = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mab_ticks_ff   <= dmx_pkg::MAB_TICKS_RST;
         start_ticks_ff <= dmx_pkg::START_TICKS_RST;
         data_ticks_ff  <= dmx_pkg::DATA_TICKS_RST;
         stop_ticks_ff  <= dmx_pkg::STOP_TICKS_RST;
         break_ticks_ff <= dmx_pkg::BREAK_TICKS_RST;
         slot_count_ff  <= dmx_pkg::SLOT_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dmx_pkg::CSR_MAB_TICKS:   mab_ticks_ff   <= csr_wdata;
            dmx_pkg::CSR_START_TICKS: start_ticks_ff <= csr_wdata;
            dmx_pkg::CSR_DATA_TICKS:  data_ticks_ff  <= csr_wdata;
            dmx_pkg::CSR_STOP_TICKS:  stop_ticks_ff  <= csr_wdata;
            dmx_pkg::CSR_BREAK_TICKS: break_ticks_ff <= csr_wdata;
            dmx_pkg::CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata[SW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= dmx_pkg::PH_IDLE;
         tick_count_ff <= '0;
         bit_pos_ff    <= '0;
         slot_pos_ff   <= '0;
         shift_byte_ff <= '0;
         line_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_pos_ff    <= bit_pos_in;
         slot_pos_ff   <= slot_pos_in;
         shift_byte_ff <= shift_byte_in;
         line_ff       <= line_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dmx_pkg::MAX_SLOTS; i++) begin
            slot_store_ff[i] <= '0;
         end
      end else if (store_we) begin
         slot_store_ff[req_slot_index] <= req_slot_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_line_ff <= line_in;
         rsp_busy_ff <= (phase_in != dmx_pkg::PH_IDLE);
         rsp_done_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dmx_pkg::RSP_DATA_WIDTH-2){1'b0}}, rsp_busy_ff, rsp_line_ff};
   assign rsp_tlast  = rsp_done_ff;

endmodule

@@ rtl/dmx_checker.sv @@
// ----------------------------------------------------------------------------
// DMX transmitter port checker
// Watches the result channel of the transmitter and flags illegal sequences.
// ----------------------------------------------------------------------------
module dmx_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dmx_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                rsp_tlast
);

   // A stalled result must hold its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The end of a packet leaves the line low and the transmitter idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[0] && !rsp_tdata[1])
      else $error("packet end while busy or line high");

   // An idle transmitter always holds the line low.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("line high while idle");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind dmx_packet_transmitter dmx_checker u_dmx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// DMX packet transmitter testbench
// Streams slot writes and microsecond ticks into the transmitter and checks
// every response against a cycle-free model of the line driver. Directed
// tests cover the reset timing, short and long durations, empty
// and saturated slot counts, requests ignored while busy and timing changes
// in the middle of a packet. A short random run of packets with noise follows.
// The request side sends in bursts and the response side stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 150;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic line;
      logic busy;
      logic done;
   } line_state_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [dmx_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [dmx_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_we = 1'b0;
   logic [dmx_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [dmx_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Model of the transmitter: timing registers and line state.
   logic [dmx_pkg::TICK_WIDTH-1:0]     mab_len, start_len, data_len, stop_len, break_len;
   logic [dmx_pkg::SLOT_CNT_WIDTH-1:0] slot_cfg;
   dmx_pkg::phase_type                 ph;
   logic [dmx_pkg::TICK_WIDTH-1:0]     tick_cnt;
   logic [dmx_pkg::BIT_POS_WIDTH-1:0]  bit_pos;
   logic [dmx_pkg::SLOT_IDX_WIDTH-1:0] slot_pos;
   logic [dmx_pkg::BYTE_WIDTH-1:0]     shift_q;
   logic [dmx_pkg::BYTE_WIDTH-1:0]     slot_mem [dmx_pkg::MAX_SLOTS];
   logic                               line_q;

   line_state_type pending_lines [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             request_count = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   int             stall_pct = 0;

   dmx_packet_transmitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void load_slot();
      ph       = dmx_pkg::PH_START;
      tick_cnt = '0;
      bit_pos  = '0;
      shift_q  = slot_mem[slot_pos];
      line_q   = 1'b0;
   endfunction

   function automatic void enter_break();
      ph       = dmx_pkg::PH_BREAK;
      tick_cnt = '0;
      line_q   = 1'b0;
   endfunction

   function automatic line_state_type dmx_line_step(bit func, logic [3:0] idx,
                                                    logic [7:0] val, bit start);
      line_state_type                 res;
      logic [dmx_pkg::TICK_WIDTH-1:0] len;
      int                             nslots;
      bit                             done;
      done   = 1'b0;
      nslots = (slot_cfg > dmx_pkg::MAX_SLOTS) ? dmx_pkg::MAX_SLOTS : int'(slot_cfg);
      len    = '0;
      if (func == dmx_pkg::FUNC_WRITE) begin
         if (ph == dmx_pkg::PH_IDLE) slot_mem[idx] = val;
      end else if (ph == dmx_pkg::PH_IDLE) begin
         if (start) begin
            ph       = dmx_pkg::PH_MAB;
            tick_cnt = '0;
            line_q   = 1'b1;
         end
      end else begin
         case (ph)
            dmx_pkg::PH_MAB:   len = mab_len;
            dmx_pkg::PH_START: len = start_len;
            dmx_pkg::PH_DATA:  len = data_len;
            dmx_pkg::PH_STOP:  len = stop_len;
            default:           len = break_len;
         endcase
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= len) begin
            tick_cnt = '0;
            case (ph)
               dmx_pkg::PH_MAB: begin
                  slot_pos = '0;
                  if (nslots == 0) enter_break();
                  else load_slot();
               end
               dmx_pkg::PH_START: begin
                  ph      = dmx_pkg::PH_DATA;
                  bit_pos = '0;
                  line_q  = shift_q[0];
               end
               dmx_pkg::PH_DATA: begin
                  shift_q = shift_q >> 1;
                  bit_pos = bit_pos + 1'b1;
                  if (bit_pos >= 8) begin
                     ph      = dmx_pkg::PH_STOP;
                     bit_pos = '0;
                     line_q  = 1'b1;
                  end else begin
                     line_q = shift_q[0];
                  end
               end
               dmx_pkg::PH_STOP: begin
                  bit_pos = bit_pos + 1'b1;
                  if (bit_pos >= dmx_pkg::STOP_BITS) begin
                     if (int'(slot_pos) + 1 >= nslots) begin
                        enter_break();
                     end else begin
                        slot_pos = slot_pos + 1'b1;
                        load_slot();
                     end
                  end
               end
               default: begin
                  ph       = dmx_pkg::PH_IDLE;
                  line_q   = 1'b0;
                  bit_pos  = '0;
                  slot_pos = '0;
                  done     = 1'b1;
               end
            endcase
         end
      end
      res.line = line_q;
      res.busy = (ph != dmx_pkg::PH_IDLE);
      res.done = done;
      return res;
   endfunction

   task automatic send_request(input bit func, input logic [3:0] idx,
                               input logic [7:0] val, input bit start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      request_count++;
      pending_lines.push_back(dmx_line_step(func, idx, val, start));
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {3'b000, start, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic set_timing(input logic [15:0] mab, input logic [15:0] st,
                             input logic [15:0] dat, input logic [15:0] stp,
                             input logic [15:0] brk, input logic [4:0] slots);
      logic [dmx_pkg::CSR_IDX_WIDTH-1:0]  regs [6];
      logic [dmx_pkg::CSR_DATA_WIDTH-1:0] vals [6];
      regs = '{dmx_pkg::CSR_MAB_TICKS, dmx_pkg::CSR_START_TICKS,
               dmx_pkg::CSR_DATA_TICKS, dmx_pkg::CSR_STOP_TICKS,
               dmx_pkg::CSR_BREAK_TICKS, dmx_pkg::CSR_SLOT_COUNT};
      vals = '{mab, st, dat, stp, brk, {11'b0, slots}};
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we     <= 1'b0;
      mab_len    = mab;
      start_len  = st;
      data_len   = dat;
      stop_len   = stp;
      break_len  = brk;
      slot_cfg   = slots;
      burst_left = 0;
   endtask

   task automatic run_packet(input bit noisy);
      send_request(dmx_pkg::FUNC_TICK, 4'($urandom), 8'($urandom), 1'b1);
      while (ph != dmx_pkg::PH_IDLE) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            send_request(dmx_pkg::FUNC_WRITE, 4'($urandom), 8'($urandom),
                         1'($urandom));
         end else begin
            send_request(dmx_pkg::FUNC_TICK, 4'($urandom), 8'($urandom),
                         noisy ? 1'($urandom) : 1'b0);
         end
      end
   endtask

   task automatic test_reset_timing();
      send_request(dmx_pkg::FUNC_TICK, 4'd0, 8'h00, 1'b0);
      send_request(dmx_pkg::FUNC_WRITE, 4'd0, 8'hA5, 1'b0);
      send_request(dmx_pkg::FUNC_WRITE, 4'd11, 8'hFF, 1'b1);
      send_request(dmx_pkg::FUNC_WRITE, 4'd15, 8'h5A, 1'b0);
      run_packet(1'b0);
   endtask

   task automatic test_shortest_timing();
      set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 5'd2);
      send_request(dmx_pkg::FUNC_WRITE, 4'd0, 8'hFF, 1'b0);
      send_request(dmx_pkg::FUNC_WRITE, 4'd1, 8'h00, 1'b0);
      run_packet(1'b0);
   endtask

   task automatic test_empty_and_full_packets();
      set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 5'd0);
      run_packet(1'b0);
      set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 5'd31);
      for (int i = 0; i < dmx_pkg::MAX_SLOTS; i++) begin
         send_request(dmx_pkg::FUNC_WRITE, 4'(i), 8'(8'h81 ^ (i * 8'h13)), 1'b0);
      end
      run_packet(1'b0);
   endtask

   task automatic test_busy_ignores();
      set_timing(16'd1, 16'd2, 16'd1, 16'd2, 16'd3, 5'd2);
      send_request(dmx_pkg::FUNC_WRITE, 4'd0, 8'h3C, 1'b0);
      send_request(dmx_pkg::FUNC_WRITE, 4'd1, 8'hC3, 1'b0);
      run_packet(1'b1);
      run_packet(1'b0);
   endtask

   task automatic test_timing_change_in_packet();
      set_timing(16'd2, 16'd2, 16'd6, 16'd2, 16'd3, 5'd2);
      send_request(dmx_pkg::FUNC_TICK, 4'd0, 8'h00, 1'b1);
      repeat (20) send_request(dmx_pkg::FUNC_TICK, 4'd0, 8'h00, 1'b0);
      set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 5'd1);
      while (ph != dmx_pkg::PH_IDLE) begin
         send_request(dmx_pkg::FUNC_TICK, 4'd0, 8'h00, 1'b0);
      end
   endtask

   task automatic test_long_timing();
      set_timing(16'd60, 16'd1, 16'd1, 16'd1, 16'd60, 5'd1);
      run_packet(1'b0);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int hi;
      stop_at = request_count + RANDOM_ITEMS;
      while (request_count < stop_at) begin
         if ($urandom_range(0, 2) == 0) begin
            hi = ($urandom_range(0, 3) == 0) ? 6 : 3;
            if ($urandom_range(0, 9) < 7) begin
               set_timing(16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)),
                          16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)),
                          16'($urandom_range(0, hi)), 5'($urandom_range(0, 4)));
            end else begin
               set_timing(16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
                          16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
                          16'($urandom_range(0, 3)), 5'($urandom_range(5, 31)));
            end
         end
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
               send_request(dmx_pkg::FUNC_TICK, 4'($urandom), 8'($urandom), 1'b0);
            end else begin
               send_request(dmx_pkg::FUNC_WRITE, 4'($urandom), 8'($urandom),
                            1'($urandom));
            end
         end
         run_packet(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : check_response
      line_state_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lines.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("response with no request waiting: data %0h last %0b",
                        rsp_tdata, rsp_tlast);
            end
         end else begin
            want = pending_lines.pop_front();
            compare_field("line_level", {7'b0, want.line}, {7'b0, rsp_tdata[0]});
            compare_field("busy_res", {7'b0, want.busy}, {7'b0, rsp_tdata[1]});
            compare_field("packet_done", {7'b0, want.done}, {7'b0, rsp_tlast});
            compare_field("padding", 8'h00, {2'b00, rsp_tdata[7:2]});
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count % 512 == 0) begin
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            default: stall_pct = 50;
         endcase
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 8);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      mab_len   = dmx_pkg::MAB_TICKS_RST;
      start_len = dmx_pkg::START_TICKS_RST;
      data_len  = dmx_pkg::DATA_TICKS_RST;
      stop_len  = dmx_pkg::STOP_TICKS_RST;
      break_len = dmx_pkg::BREAK_TICKS_RST;
      slot_cfg  = dmx_pkg::SLOT_COUNT_RST;
      ph        = dmx_pkg::PH_IDLE;
      tick_cnt  = '0;
      bit_pos   = '0;
      slot_pos  = '0;
      shift_q   = '0;
      line_q    = 1'b0;
      for (int i = 0; i < dmx_pkg::MAX_SLOTS; i++) slot_mem[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_timing();
      test_shortest_timing();
      test_empty_and_full_packets();
      test_busy_ignores();
      test_timing_change_in_packet();
      test_long_timing();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
